### rtl/core/clbs_pkg.sv
`timescale 1ns / 1ps
package clbs_pkg;

   localparam int MAX_RIGIDS_DEF   = 1024;
   localparam int MAX_CLUSTERS_DEF = 256;
   localparam int IDX_W            = 11;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_AW           = 3;
   localparam int REQ_TDATA_W      = 192;
   localparam int RSP_TDATA_W      = 144;
   localparam int TR_W             = 160;
   localparam int REST_W           = 96;

   localparam logic [1:0] MODE_LOAD_TR   = 2'd0;
   localparam logic [1:0] MODE_LOAD_REST = 2'd1;
   localparam logic [1:0] MODE_INFL      = 2'd2;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;

   localparam logic REG_BONE_BASE = 1'b0;

   typedef logic signed [15:0] s16_type;
   typedef logic signed [17:0] s18_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [33:0] s34_type;
   typedef logic signed [35:0] s36_type;
   typedef logic signed [47:0] s48_type;

   typedef enum logic [1:0] {
      K_LOAD_TR   = 2'd0,
      K_LOAD_REST = 2'd1,
      K_INFL      = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic                     skip;
      logic [IDX_W-1:0]         rig;
      logic [IDX_W-1:0]         cl;
      s32_type [2:0]            a;
      s16_type [2:0]            b;
      logic signed [15:0]       qw;
      logic [15:0]              w;
      logic                     last;
   } entry_type;

   function automatic logic signed [31:0] sat41_32(input logic signed [40:0] x);
      if (&x[40:31] || ~|x[40:31]) return x[31:0];
      return x[40] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   function automatic logic signed [15:0] sat41_16(input logic signed [40:0] x);
      if (&x[40:15] || ~|x[40:15]) return x[15:0];
      return x[40] ? 16'sh8000 : 16'sh7fff;
   endfunction

   function automatic logic signed [31:0] sat33_32(input logic signed [32:0] x);
      if (x[32] == x[31]) return x[31:0];
      return x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   function automatic logic signed [47:0] sat49_48(input logic signed [48:0] x);
      if (x[48] == x[47]) return x[47:0];
      return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
   endfunction

   function automatic logic signed [35:0] sat37_36(input logic signed [36:0] x);
      if (x[36] == x[35]) return x[35:0];
      return x[36] ? {1'b1, 35'd0} : {1'b0, {35{1'b1}}};
   endfunction

   function automatic logic signed [31:0] sat48_32(input logic signed [47:0] x);
      if (&x[47:31] || ~|x[47:31]) return x[31:0];
      return x[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   function automatic logic signed [15:0] sat36_16(input logic signed [35:0] x);
      if (&x[35:15] || ~|x[35:15]) return x[15:0];
      return x[35] ? 16'sh8000 : 16'sh7fff;
   endfunction

endpackage

### rtl/core/clbs_ram.sv
`timescale 1ns / 1ps
module clbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/clbs_front.sv
`timescale 1ns / 1ps
module clbs_front #(
   parameter int MAX_RIGIDS   = clbs_pkg::MAX_RIGIDS_DEF,
   parameter int MAX_CLUSTERS = clbs_pkg::MAX_CLUSTERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [clbs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   input  logic [9:0]                         bone_base,
   input  logic                               pop,
   output logic                               head_valid,
   output clbs_pkg::entry_type                head
);
   import clbs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type         q_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]       cnt_ff, cnt_in;
   entry_type         ent;
   logic              keep, push;
   logic              slot_neg, rig_ok, cl_ok, infl_ok;
   logic [31:0]       slot_u, rig_sum;

   always_comb begin
      slot_neg = req_tdata[10];
      slot_u   = 32'(req_tdata[9:0]);
      rig_sum  = slot_u + 32'(bone_base);
      rig_ok   = !slot_neg && (slot_u < 32'(MAX_RIGIDS));
      cl_ok    = !slot_neg && (slot_u < 32'(MAX_CLUSTERS));
      infl_ok  = cl_ok && (rig_sum < 32'(MAX_RIGIDS));

      ent.rig  = IDX_W'(slot_u);
      ent.cl   = IDX_W'(slot_u);
      ent.a[0] = req_tdata[42:11];
      ent.a[1] = req_tdata[74:43];
      ent.a[2] = req_tdata[106:75];
      ent.b[0] = req_tdata[122:107];
      ent.b[1] = req_tdata[138:123];
      ent.b[2] = req_tdata[154:139];
      ent.qw   = req_tdata[170:155];
      ent.w    = req_tdata[186:171];
      ent.last = req_tlast;
      ent.skip = 1'b0;
      ent.kind = K_INFL;
      keep     = 1'b0;
      case (req_tuser)
         MODE_LOAD_TR: begin
            ent.kind = K_LOAD_TR;
            keep     = rig_ok;
         end
         MODE_LOAD_REST: begin
            ent.kind = K_LOAD_REST;
            keep     = cl_ok;
         end
         MODE_INFL: begin
            ent.kind = K_INFL;
            ent.rig  = IDX_W'(rig_sum);
            ent.skip = !infl_ok;
            keep     = infl_ok || req_tlast;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_tready = (cnt_ff < (PW+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= ent;
      end
   end
endmodule

### rtl/core/clbs_back.sv
`timescale 1ns / 1ps
module clbs_back #(
   parameter int MAX_RIGIDS   = clbs_pkg::MAX_RIGIDS_DEF,
   parameter int MAX_CLUSTERS = clbs_pkg::MAX_CLUSTERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  clbs_pkg::entry_type               head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [clbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import clbs_pkg::*;

   localparam int RAW = $clog2(MAX_RIGIDS);
   localparam int CAW = $clog2(MAX_CLUSTERS);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_RD   = 10'b00_0000_0010,
      S_LOC  = 10'b00_0000_0100,
      S_CP   = 10'b00_0000_1000,
      S_CN   = 10'b00_0001_0000,
      S_RP   = 10'b00_0010_0000,
      S_RN   = 10'b00_0100_0000,
      S_SK   = 10'b00_1000_0000,
      S_WP   = 10'b01_0000_0000,
      S_ACC  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   entry_type cur_ff, cur_in;

   logic [TR_W-1:0]   tr_rdata;
   logic [REST_W-1:0] rest_rdata;
   logic              tr_we, rest_we;

   s32_type [2:0]           loc_ff, loc_in, rp_ff, rp_in, sk_ff, sk_in;
   s36_type [2:0]           tp_ff, tp_in, tn_ff, tn_in;
   s16_type [2:0]           rn_ff, rn_in;
   s34_type [2:0]           pw_ff, pw_in;
   s18_type [2:0]           nw_ff, nw_in;
   s48_type [2:0]           pacc_ff, pacc_in, psum;
   s36_type [2:0]           nacc_ff, nacc_in, nsum;
   logic                    out_vld_ff, out_vld_in;
   logic [RSP_TDATA_W-1:0]  out_ff, out_in;

   logic signed [15:0]      qx, qy, qz, qw;
   s32_type [2:0]           vsel;
   s36_type [2:0]           tsel;
   s36_type [2:0]           tcalc;
   logic signed [2:0][40:0] ocalc;
   logic signed [48:0]      c0, c1, c2;
   logic signed [49:0]      cr0, cr1, cr2;
   logic signed [53:0]      s0, s1, s2;
   logic signed [16:0]      wext;
   logic signed [49:0]      pprod;
   logic signed [33:0]      nprod;
   logic                    out_free;

   clbs_ram #(.WIDTH(TR_W), .DEPTH(MAX_RIGIDS)) u_tr_ram (
      .clock (clock),
      .we    (tr_we),
      .waddr (RAW'(head.rig)),
      .wdata ({head.qw, head.b[2], head.b[1], head.b[0],
               head.a[2], head.a[1], head.a[0]}),
      .raddr (RAW'(cur_ff.rig)),
      .rdata (tr_rdata)
   );

   clbs_ram #(.WIDTH(REST_W), .DEPTH(MAX_CLUSTERS)) u_rest_ram (
      .clock (clock),
      .we    (rest_we),
      .waddr (CAW'(head.cl)),
      .wdata ({head.a[2], head.a[1], head.a[0]}),
      .raddr (CAW'(cur_ff.cl)),
      .rdata (rest_rdata)
   );

   assign pop     = (state_ff == S_IDLE) && head_valid;
   assign tr_we   = pop && (head.kind == K_LOAD_TR);
   assign rest_we = pop && (head.kind == K_LOAD_REST);

   assign qx = tr_rdata[111:96];
   assign qy = tr_rdata[127:112];
   assign qz = tr_rdata[143:128];
   assign qw = tr_rdata[159:144];

   always_comb begin
      if (state_ff == S_CP || state_ff == S_RP) begin
         vsel = loc_ff;
         tsel = tp_ff;
      end else begin
         for (int i = 0; i < 3; i++) begin
            vsel[i] = 32'(cur_ff.b[i]);
         end
         tsel = tn_ff;
      end
      c0  = 49'(qy * vsel[2]) - 49'(qz * vsel[1]);
      c1  = 49'(qz * vsel[0]) - 49'(qx * vsel[2]);
      c2  = 49'(qx * vsel[1]) - 49'(qy * vsel[0]);
      cr0 = 50'(c0) + 50'sd4096;
      cr1 = 50'(c1) + 50'sd4096;
      cr2 = 50'(c2) + 50'sd4096;
      tcalc[0] = cr0[48:13];
      tcalc[1] = cr1[48:13];
      tcalc[2] = cr2[48:13];
      s0 = 54'(qw * tsel[0]) + 54'(qy * tsel[2]) - 54'(qz * tsel[1]) + 54'sd8192;
      s1 = 54'(qw * tsel[1]) + 54'(qz * tsel[0]) - 54'(qx * tsel[2]) + 54'sd8192;
      s2 = 54'(qw * tsel[2]) + 54'(qx * tsel[1]) - 54'(qy * tsel[0]) + 54'sd8192;
      ocalc[0] = 41'(vsel[0]) + 41'($signed(s0[53:14]));
      ocalc[1] = 41'(vsel[1]) + 41'($signed(s1[53:14]));
      ocalc[2] = 41'(vsel[2]) + 41'($signed(s2[53:14]));
   end

   assign out_free = !out_vld_ff || rsp_tready;
   assign wext     = {1'b0, cur_ff.w};

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      loc_in     = loc_ff;
      tp_in      = tp_ff;
      tn_in      = tn_ff;
      rp_in      = rp_ff;
      rn_in      = rn_ff;
      sk_in      = sk_ff;
      pw_in      = pw_ff;
      nw_in      = nw_ff;
      pacc_in    = pacc_ff;
      nacc_in    = nacc_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      pprod      = '0;
      nprod      = '0;
      for (int i = 0; i < 3; i++) begin
         psum[i] = cur_ff.skip ? pacc_ff[i] :
                   sat49_48(49'(pacc_ff[i]) + 49'(pw_ff[i]));
         nsum[i] = cur_ff.skip ? nacc_ff[i] :
                   sat37_36(37'(nacc_ff[i]) + 37'(nw_ff[i]));
      end
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               cur_in = head;
               if (head.kind == K_INFL) begin
                  state_in = head.skip ? S_ACC : S_RD;
               end
            end
         end
         S_RD: state_in = S_LOC;
         S_LOC: begin
            for (int i = 0; i < 3; i++) begin
               loc_in[i] = sat33_32(33'(cur_ff.a[i]) -
                                    33'($signed(rest_rdata[32*i +: 32])));
            end
            state_in = S_CP;
         end
         S_CP: begin
            tp_in    = tcalc;
            state_in = S_CN;
         end
         S_CN: begin
            tn_in    = tcalc;
            state_in = S_RP;
         end
         S_RP: begin
            for (int i = 0; i < 3; i++) begin
               rp_in[i] = sat41_32(ocalc[i]);
            end
            state_in = S_RN;
         end
         S_RN: begin
            for (int i = 0; i < 3; i++) begin
               rn_in[i] = sat41_16(ocalc[i]);
            end
            state_in = S_SK;
         end
         S_SK: begin
            for (int i = 0; i < 3; i++) begin
               sk_in[i] = sat33_32(33'($signed(tr_rdata[32*i +: 32])) + 33'(rp_ff[i]));
            end
            state_in = S_WP;
         end
         S_WP: begin
            for (int i = 0; i < 3; i++) begin
               pprod    = 50'(sk_ff[i] * wext) + 50'sd32768;
               nprod    = 34'(rn_ff[i] * wext) + 34'sd32768;
               pw_in[i] = pprod[49:16];
               nw_in[i] = nprod[33:16];
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            if (!cur_ff.last) begin
               pacc_in  = psum;
               nacc_in  = nsum;
               state_in = S_IDLE;
            end else if (out_free) begin
               for (int i = 0; i < 3; i++) begin
                  out_in[32*i +: 32]    = sat48_32(psum[i]);
                  out_in[96+16*i +: 16] = sat36_16(nsum[i]);
               end
               out_vld_in = 1'b1;
               pacc_in    = '0;
               nacc_in    = '0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
         pacc_ff    <= '0;
         nacc_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         pacc_ff    <= pacc_in;
         nacc_ff    <= nacc_in;
      end
      cur_ff <= cur_in;
      loc_ff <= loc_in;
      tp_ff  <= tp_in;
      tn_ff  <= tn_in;
      rp_ff  <= rp_in;
      rn_ff  <= rn_in;
      sk_ff  <= sk_in;
      pw_ff  <= pw_in;
      nw_ff  <= nw_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
endmodule

### rtl/core/cluster_linear_blend_skinning_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// req     | in  | tvalid / tready  | tdata (slot, vec_a, vec_b, quat_w, weight), tuser mode,
//         |     |                  | tlast last_influence
// rsp     | out | tvalid / tready  | tdata (skinned xyz, normal xyz)
// csr     | in  | APB write / read | bone_base at address 0
//
// Loads are written to their table when popped; an influence runs on a sequencer that
// steps one shared rotation datapath through both rotations and the weighting.
// A two-entry queue lets req accept while the back end works; rsp has its own register.
// Synchronous active-high reset clears control and accumulators; tables are not cleared.
// A last influence holds in the accumulate step while the rsp register is full.
module cluster_linear_blend_skinning_top #(
   parameter int MAX_RIGIDS   = clbs_pkg::MAX_RIGIDS_DEF,
   parameter int MAX_CLUSTERS = clbs_pkg::MAX_CLUSTERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, quat_w, blend_weight
   input  logic [clbs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // skinned_x, skinned_y, skinned_z, normal_out_x, normal_out_y, normal_out_z
   output logic [clbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [clbs_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import clbs_pkg::*;

   logic [9:0] bone_base_ff;
   logic       head_valid, pop;
   entry_type  head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BONE_BASE) ? 32'(bone_base_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_BONE_BASE) begin
         bone_base_ff <= csr_pwdata[9:0];
      end
   end

   clbs_front #(.MAX_RIGIDS(MAX_RIGIDS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .bone_base  (bone_base_ff),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   clbs_back #(.MAX_RIGIDS(MAX_RIGIDS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

### rtl/core/clbs_checker.sv
`timescale 1ns / 1ps
module clbs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [clbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [clbs_pkg::CSR_AW-1:0]       csr_paddr,
   input logic [31:0]                       csr_pwdata,
   input logic [31:0]                       csr_prdata,
   input logic                              csr_pready
);
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
      csr_paddr[2] == clbs_pkg::REG_BONE_BASE
      |=> csr_paddr[2] != clbs_pkg::REG_BONE_BASE ||
          csr_prdata == {22'd0, $past(csr_pwdata[9:0])})
      else $error("bone_base readback mismatch");
endmodule

bind cluster_linear_blend_skinning_top clbs_checker u_clbs_checker (.*);

### dv/cluster_linear_blend_skinning_top_test.sv
`timescale 1ns / 1ps
module cluster_linear_blend_skinning_top_test;
   import clbs_pkg::*;

   localparam int NRIG = MAX_RIGIDS_DEF;
   localparam int NCL = MAX_CLUSTERS_DEF;
   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE = 40;
   localparam logic [CSR_AW-1:0] BONE_BASE_ADDR = {REG_BONE_BASE, 2'b00};

   typedef logic signed [2:0][63:0] vec3_type;

   typedef struct {
      logic [1:0]              mode;
      logic signed [10:0]      slot;
      logic [2:0][31:0]        a;
      logic [2:0][15:0]        b;
      logic signed [15:0]      qw;
      logic [15:0]             w;
      logic                    last;
   } skin_item_type;

   typedef struct {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] nrm;
   } vertex_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   cluster_linear_blend_skinning_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   skin_item_type skin_queue[$];
   vertex_out_type vertices_due[$];
   skin_item_type in_flight;

   // predictor state
   logic signed [31:0] xlat[NRIG][3];
   logic signed [15:0] quat[NRIG][4];
   logic signed [31:0] rest_pose[NCL][3];
   longint pos_sum[3];
   longint nrm_sum[3];
   logic [9:0] bone_base_q = '0;

   // generator shadow of which entries hold data
   bit tr_loaded[NRIG];
   bit rest_loaded[NCL];
   int gen_base = 0;

   int errors = 0;
   int n_items = 0;
   int n_vertices = 0;
   int n_csr = 0;
   int quiet = 0;
   bit req_took = 1'b0;
   bit idle_on = 1'b1;
   int req_gap = 0;
   int rsp_stall = 0;

   function automatic longint round_sh(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint x, int bits);
      longint hi = (longint'(1) <<< (bits - 1)) - 1;
      longint lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic vec3_type rotate_vec(longint qx, longint qy, longint qz, longint qw,
                                           vec3_type v, int bits);
      longint vx = $signed(v[0]);
      longint vy = $signed(v[1]);
      longint vz = $signed(v[2]);
      longint t0, t1, t2;
      vec3_type o;
      t0 = round_sh(qy * vz - qz * vy, 13);
      t1 = round_sh(qz * vx - qx * vz, 13);
      t2 = round_sh(qx * vy - qy * vx, 13);
      o[0] = clip(vx + round_sh(qw * t0 + (qy * t2 - qz * t1), 14), bits);
      o[1] = clip(vy + round_sh(qw * t1 + (qz * t0 - qx * t2), 14), bits);
      o[2] = clip(vz + round_sh(qw * t2 + (qx * t1 - qy * t0), 14), bits);
      return o;
   endfunction

   task automatic blend_step(skin_item_type it);
      int slot = int'(it.slot);
      int rig = int'(it.slot) + int'(bone_base_q);
      vec3_type loc, nv, rp, rn;
      vertex_out_type vo;
      longint sk;
      if (it.mode == MODE_LOAD_TR) begin
         if (slot >= 0 && slot < NRIG) begin
            for (int i = 0; i < 3; i++) begin
               xlat[slot][i] = it.a[i];
               quat[slot][i] = it.b[i];
            end
            quat[slot][3] = it.qw;
         end
      end else if (it.mode == MODE_LOAD_REST) begin
         if (slot >= 0 && slot < NCL)
            for (int i = 0; i < 3; i++) rest_pose[slot][i] = it.a[i];
      end else if (it.mode == MODE_INFL) begin
         if (slot >= 0 && slot < NCL && rig < NRIG) begin
            for (int i = 0; i < 3; i++) begin
               loc[i] = clip(longint'($signed(it.a[i])) - rest_pose[slot][i], 32);
               nv[i] = longint'($signed(it.b[i]));
            end
            rp = rotate_vec(quat[rig][0], quat[rig][1], quat[rig][2], quat[rig][3], loc, 32);
            rn = rotate_vec(quat[rig][0], quat[rig][1], quat[rig][2], quat[rig][3], nv, 16);
            for (int i = 0; i < 3; i++) begin
               sk = clip(longint'(xlat[rig][i]) + $signed(rp[i]), 32);
               pos_sum[i] = clip(pos_sum[i] + round_sh(sk * longint'(it.w), 16), 48);
               nrm_sum[i] = clip(nrm_sum[i] + round_sh($signed(rn[i]) * longint'(it.w), 16),
                                 36);
            end
         end
         if (it.last) begin
            for (int i = 0; i < 3; i++) begin
               vo.pos[i] = 32'(clip(pos_sum[i], 32));
               vo.nrm[i] = 16'(clip(nrm_sum[i], 16));
               pos_sum[i] = 0;
               nrm_sum[i] = 0;
            end
            vertices_due.insert(vertices_due.size(), vo);
         end
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (skin_queue.size() > 0) begin
            in_flight = skin_queue.pop_front();
            req_tdata <= {5'd0, in_flight.w, in_flight.qw, in_flight.b, in_flight.a,
                          in_flight.slot};
            req_tuser <= in_flight.mode;
            req_tlast <= in_flight.last;
            req_tvalid <= 1'b1;
            if (idle_on && $urandom_range(3) == 0) req_gap = $urandom_range(1, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(4) == 0) rsp_stall = $urandom_range(1, 6);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      vertex_out_type want;
      logic [2:0][31:0] got_pos;
      logic [2:0][15:0] got_nrm;
      bit busy;
      busy = 1'b0;
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) begin
         blend_step(in_flight);
         n_items++;
         busy = 1'b1;
      end
      if (!reset && csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr == BONE_BASE_ADDR) bone_base_q = csr_pwdata[9:0];
         n_csr++;
         busy = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         busy = 1'b1;
         n_vertices++;
         got_pos = rsp_tdata[95:0];
         got_nrm = rsp_tdata[143:96];
         if (vertices_due.size() == 0) begin
            $display("%0t: unexpected vertex result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = vertices_due.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (got_pos[i] !== want.pos[i]) begin
                  $display("%0t: skinned[%0d] expected %h actual %h", $time, i,
                           want.pos[i], got_pos[i]);
                  errors++;
               end
               if (got_nrm[i] !== want.nrm[i]) begin
                  $display("%0t: normal_out[%0d] expected %h actual %h", $time, i,
                           want.nrm[i], got_nrm[i]);
                  errors++;
               end
            end
         end
      end
      quiet = busy ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_q();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3, 4: return 16'($urandom_range(0, 32767) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_w();
      case ($urandom_range(7))
         0: return 16'hffff;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_item(logic [1:0] mode, int slot, logic last);
      skin_item_type it;
      it.mode = mode;
      it.slot = 11'(slot);
      for (int i = 0; i < 3; i++) begin
         it.a[i] = rand_pos();
         it.b[i] = rand_q();
      end
      it.qw = rand_q();
      it.w = rand_w();
      it.last = last;
      if (mode == MODE_LOAD_TR && slot >= 0) tr_loaded[slot] = 1'b1;
      if (mode == MODE_LOAD_REST && slot >= 0 && slot < NCL) rest_loaded[slot] = 1'b1;
      skin_queue.insert(skin_queue.size(), it);
   endtask

   task automatic push_fixed(logic [1:0] mode, int slot, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] az, logic [15:0] bx, logic [15:0] by,
                             logic [15:0] bz, logic [15:0] qw, logic [15:0] w, logic last);
      skin_item_type it;
      it.mode = mode;
      it.slot = 11'(slot);
      it.a = {az, ay, ax};
      it.b = {bz, by, bx};
      it.qw = qw;
      it.w = w;
      it.last = last;
      if (mode == MODE_LOAD_TR && slot >= 0) tr_loaded[slot] = 1'b1;
      if (mode == MODE_LOAD_REST && slot >= 0 && slot < NCL) rest_loaded[slot] = 1'b1;
      skin_queue.insert(skin_queue.size(), it);
   endtask

   // pick a cluster whose transform and rest pose are both loaded, or a skipped one
   function automatic int pick_cluster();
      int ok[$];
      for (int c = 0; c < NCL; c++)
         if (c + gen_base < NRIG && rest_loaded[c] && tr_loaded[c + gen_base])
            ok.insert(ok.size(), c);
      if (ok.size() > 0 && $urandom_range(6) != 0) return ok[$urandom_range(ok.size() - 1)];
      case ($urandom_range(2))
         0: return -1;
         1: return $urandom_range(NCL, 1023);
         default: return (gen_base > NRIG - NCL) ? $urandom_range(NRIG - gen_base, NCL - 1) : -1;
      endcase
   endfunction

   task automatic csr_write(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= BONE_BASE_ADDR;
      csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      gen_base = int'(value[9:0]);
   endtask

   task automatic drain();
      while (!(skin_queue.size() == 0 && !req_tvalid && vertices_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int c, n, cmax;
      cmax = (NRIG - 1 - gen_base < NCL - 1) ? NRIG - 1 - gen_base : NCL - 1;
      for (int k = 0; k < 6; k++) begin
         c = $urandom_range(0, cmax);
         push_item(MODE_LOAD_TR, c + gen_base, 1'($urandom_range(1)));
         push_item(MODE_LOAD_REST, c, 1'($urandom_range(1)));
      end
      while (count > 0) begin
         case ($urandom_range(11))
            0: begin
               c = $urandom_range(9) == 0 ? -1 : gen_base + $urandom_range(0, cmax);
               push_item(MODE_LOAD_TR, c, 1'($urandom_range(1)));
               count--;
            end
            1: begin
               c = $urandom_range(9) == 0 ? $urandom_range(NCL, 1023) : $urandom_range(0, cmax);
               push_item(MODE_LOAD_REST, c, 1'($urandom_range(1)));
               count--;
            end
            2: push_item(MODE_UNUSED, $urandom_range(0, 1023), 1'($urandom_range(1)));
            default: begin
               n = $urandom_range(1, 4);
               for (int j = 0; j < n; j++)
                  push_item(MODE_INFL, pick_cluster(),
                            (j == n - 1) && ($urandom_range(9) != 0));
               count -= n;
            end
         endcase
      end
   endtask

   initial begin
      int bases[4];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(32'd0);
      push_fixed(MODE_LOAD_TR, 0, 32'h0001_0000, 32'hfffe_0000, 32'h0003_0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0);
      push_fixed(MODE_LOAD_TR, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 1'b1);
      push_fixed(MODE_LOAD_TR, 2, 32'h0, 32'h0, 32'h0,
                 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0);
      push_fixed(MODE_LOAD_REST, 0, 32'h0, 32'h0, 32'h0,
                 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
      push_fixed(MODE_LOAD_REST, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_2345,
                 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1);
      push_fixed(MODE_LOAD_REST, 2, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
      push_fixed(MODE_LOAD_TR, -1, 32'hdead_beef, 32'h1, 32'h2,
                 16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 1'b0);
      push_fixed(MODE_LOAD_REST, -1, 32'h1234_5678, 32'h1, 32'h2,
                 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
      push_fixed(MODE_LOAD_REST, NCL, 32'h5555_5555, 32'haaaa_aaaa, 32'h1,
                 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
      push_fixed(MODE_UNUSED, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      push_fixed(MODE_INFL, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                 16'h7fff, 16'h8000, 16'h4000, 16'h0, 16'hffff, 1'b0);
      push_fixed(MODE_INFL, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h8000, 1'b0);
      push_fixed(MODE_INFL, 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 16'h7fff, 16'h7fff, 16'h7fff, 16'h0, 16'h0000, 1'b1);
      push_fixed(MODE_INFL, -1, 32'h1, 32'h2, 32'h3,
                 16'h1, 16'h2, 16'h3, 16'h0, 16'hffff, 1'b1);
      push_fixed(MODE_INFL, 300, 32'h1, 32'h2, 32'h3,
                 16'h1, 16'h2, 16'h3, 16'h0, 16'hffff, 1'b0);
      push_fixed(MODE_INFL, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0001, 1'b1);
      push_fixed(MODE_INFL, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 16'h7fff, 16'h7fff, 16'h8000, 16'h0, 16'hffff, 1'b1);
      drain();

      bases[0] = 1023;
      bases[1] = $urandom_range(1, 767);
      bases[2] = $urandom_range(769, 1022);
      bases[3] = 0;
      for (int p = 0; p < 4; p++) begin
         csr_write(bases[p]);
         idle_on = (p != 3);
         random_phase(150);
         drain();
      end

      $display("covered %0d items and %0d vertex results over %0d bone_base writes,",
               n_items, n_vertices, n_csr);
      $display("including table loads, skipped clusters, ignored items and saturation");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### cluster_linear_blend_skinning_top.f
rtl/core/clbs_pkg.sv
rtl/core/clbs_ram.sv
rtl/core/clbs_front.sv
rtl/core/clbs_back.sv
rtl/core/cluster_linear_blend_skinning_top.sv
rtl/core/clbs_checker.sv
dv/cluster_linear_blend_skinning_top_test.sv
